@@ rtl/osde_pkg.sv @@
package osde_pkg;

    localparam int UnitBits = 16;

    localparam logic [UnitBits-1:0] ChEsc    = 16'h001B;
    localparam logic [UnitBits-1:0] ChBel    = 16'h0007;
    localparam logic [UnitBits-1:0] ChBslash = 16'h005C;

    localparam logic [2:0] InValue = 3'd6;

    localparam logic [15:0] LimitReset = 16'd32768;

    localparam logic [1:0] KindValue   = 2'd0;
    localparam logic [1:0] KindEnd     = 2'd1;
    localparam logic [1:0] KindAbandon = 2'd2;

    localparam int ResultDepth = 4;

    typedef struct packed {
        logic [2:0]          matched;
        logic                esc;
        logic [15:0]         count;
    } t_state;

    typedef struct packed {
        logic [UnitBits-1:0] value;
        logic [1:0]          kind;
        logic                last;
    } t_result;

    // Expected unit at each position of the prefix ESC ] 9 ; 9 ;.
    function automatic logic [UnitBits-1:0] prefix_unit(input logic [2:0] pos);
        logic [UnitBits-1:0] u;
        unique case (pos)
            3'd0:    u = 16'h001B;
            3'd1:    u = 16'h005D;
            3'd2:    u = 16'h0039;
            3'd3:    u = 16'h003B;
            3'd4:    u = 16'h0039;
            3'd5:    u = 16'h003B;
            default: u = '0;
        endcase
        return u;
    endfunction

    // One step of the prefix matcher. A mismatching ESC restarts the match at one.
    function automatic t_state scan_unit(input logic [2:0] m_in, input logic [UnitBits-1:0] c);
        t_state      s;
        logic [2:0]  m;
        m = (m_in >= InValue) ? 3'd0 : m_in;
        if (c == prefix_unit(m)) begin
            m = m + 3'd1;
        end else if (c == ChEsc) begin
            m = 3'd1;
        end else begin
            m = 3'd0;
        end
        s.matched = m;
        s.esc     = 1'b0;
        s.count   = {13'd0, m};
        return s;
    endfunction

endpackage

@@ rtl/osde_step.sv @@
module osde_step
    import osde_pkg::*;
(
    input  t_state              i_state,
    input  logic [UnitBits-1:0] i_unit,
    input  logic [15:0]         i_limit,
    output t_state              o_state,
    output logic [1:0]          o_nres,
    output t_result             o_res0,
    output t_result             o_res1
);

    always_comb begin
        t_state      st;
        t_result     r0;
        t_result     r1;
        t_result     rn;
        logic [1:0]  nres;
        logic        done;
        logic [16:0] next_cnt;

        st       = i_state;
        r0       = '0;
        r1       = '0;
        rn       = '0;
        nres     = 2'd0;
        done     = 1'b0;
        next_cnt = '0;

        if (st.matched != InValue) begin
            st = scan_unit(st.matched, i_unit);
        end else begin
            if (st.esc) begin
                st.esc   = 1'b0;
                next_cnt = {1'b0, st.count} + 17'd1;
                if (i_unit == ChBslash) begin
                    r0.kind = KindEnd;
                    nres    = 2'd1;
                    st      = '0;
                    done    = 1'b1;
                end else if (next_cnt > {1'b0, i_limit}) begin
                    r0.kind = KindAbandon;
                    nres    = 2'd1;
                    st      = scan_unit(3'd0, i_unit);
                    done    = 1'b1;
                end else begin
                    st.count = next_cnt[15:0];
                    r0.value = ChEsc;
                    r0.kind  = KindValue;
                    nres     = 2'd1;
                end
            end

            if (!done) begin
                next_cnt = {1'b0, st.count} + 17'd1;
                rn       = '0;
                if (i_unit == ChBel) begin
                    rn.kind = KindEnd;
                    st      = '0;
                end else if (i_unit == ChEsc) begin
                    st.esc = 1'b1;
                end else if (next_cnt > {1'b0, i_limit}) begin
                    rn.kind = KindAbandon;
                    st      = scan_unit(3'd0, i_unit);
                end else begin
                    st.count = next_cnt[15:0];
                    rn.value = i_unit;
                    rn.kind  = KindValue;
                end
                // Every branch but a held ESC gives one more result.
                if (!(i_unit == ChEsc && i_unit != ChBel)) begin
                    if (nres == 2'd0) begin
                        r0 = rn;
                    end else begin
                        r1 = rn;
                    end
                    nres = nres + 2'd1;
                end
            end
        end

        if (nres == 2'd1) begin
            r0.last = 1'b1;
        end
        if (nres == 2'd2) begin
            r1.last = 1'b1;
        end

        o_state = st;
        o_nres  = nres;
        o_res0  = r0;
        o_res1  = r1;
    end

endmodule

@@ rtl/osde_result_buf.sv @@
module osde_result_buf
    import osde_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_result    i_res0,
    input  t_result    i_res1,
    output logic       o_space,
    output logic       o_valid,
    output t_result    o_res,
    input  logic       i_pop,
    output logic [$clog2(ResultDepth):0] o_count
);

    localparam int PtrBits = $clog2(ResultDepth);

    t_result              r_mem [ResultDepth];
    logic [PtrBits-1:0]   r_wr_ptr;
    logic [PtrBits-1:0]   r_rd_ptr;
    logic [PtrBits:0]     r_count;
    logic [PtrBits-1:0]   n_wr_ptr;
    logic [PtrBits-1:0]   n_rd_ptr;
    logic [PtrBits:0]     n_count;
    logic                 w_pop;
    logic [PtrBits-1:0]   w_wr_ptr1;

    assign w_pop     = i_pop && (r_count != '0);
    assign w_wr_ptr1 = r_wr_ptr + PtrBits'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PtrBits'(i_push_n);
        n_rd_ptr = r_rd_ptr + PtrBits'(w_pop);
        n_count  = r_count + (PtrBits + 1)'(i_push_n) - (PtrBits + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_res1;
        end
    end

    // Room for the two results that one request can cause.
    assign o_space = (r_count <= (PtrBits + 1)'(ResultDepth - 2));
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

@@ rtl/osc_directory_sequence_extractor_unit.sv @@
// Directory sequence extractor.
// Input stream (s_axis): one 16-bit terminal code unit per request. The block
// watches for the prefix ESC ] 9 ; 9 ; and then streams each value unit out.
// Output stream (m_axis): tdata carries the value unit, tuser the kind
// (0 value unit, 1 end of value, 2 abandoned on overflow), tlast marks the
// final result caused by one input request. An input request gives zero, one
// or two results.
// Results of a request are written to the result buffer at the clock edge that
// accepts it. One request is taken every cycle as long as the four-entry result
// buffer has room for two results; the sustained rate is one request per
// cycle when each causes at most one result, and set by the single output
// port otherwise.
// When the receiver stalls, results wait in the buffer and s_axis_tready
// drops once fewer than two entries are free; nothing is lost.
// Reset (synchronous, active low) empties the buffer, returns the matcher to
// scanning and sets pending_limit (APB, byte address 0) to 32768.
module osc_directory_sequence_extractor_unit
    import osde_pkg::*;
#(
    parameter int UNIT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] value_unit
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [UnitBits-1:0] UnitMask = (UNIT_WIDTH >= UnitBits) ? {UnitBits{1'b1}}
        : UnitBits'((33'd1 << UNIT_WIDTH) - 33'd1);

    t_state              r_state;
    t_state              n_state;
    logic [15:0]         r_limit;
    logic [UnitBits-1:0] w_unit;
    logic [1:0]          w_nres;
    t_result             w_res0;
    t_result             w_res1;
    t_result             w_out;
    logic                w_space;
    logic                w_accept;
    logic [1:0]          w_push_n;
    logic [$clog2(ResultDepth):0] w_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_limit <= pwdata[15:0];
        end
    end

    assign w_unit        = s_axis_tdata & UnitMask;
    assign s_axis_tready = w_space;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_push_n      = w_accept ? w_nres : 2'd0;

    osde_step u_step (
        .i_state (r_state),
        .i_unit  (w_unit),
        .i_limit (r_limit),
        .o_state (n_state),
        .o_nres  (w_nres),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    osde_result_buf u_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_res0   (w_res0),
        .i_res1   (w_res1),
        .o_space  (w_space),
        .o_valid  (m_axis_tvalid),
        .o_res    (w_out),
        .i_pop    (m_axis_tready),
        .o_count  (w_count)
    );

    assign m_axis_tdata = w_out.value;
    assign m_axis_tuser = w_out.kind;
    assign m_axis_tlast = w_out.last;

`ifndef SYNTHESIS
    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> w_count <= ($clog2(ResultDepth) + 1)'(ResultDepth - 2))
        else $error("request accepted without room for two results");

    a_esc_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.esc |-> r_state.matched == InValue)
        else $error("held ESC outside a value");

    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.matched != InValue |-> r_state.count == {13'd0, r_state.matched})
        else $error("pending count does not follow the prefix match while scanning");

    a_value_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.matched == InValue |-> r_state.count >= 16'd6)
        else $error("pending count below prefix length inside a value");
`endif

endmodule

@@ sim/osc_directory_sequence_extractor_unit_tb.sv @@
module osc_directory_sequence_extractor_unit_tb;
    import osde_pkg::*;

    localparam int          ClkPeriod   = 12;
    localparam int          CycleLimit  = 600000;
    localparam int          SettleWait  = 10;
    localparam int          LongHold    = 300;
    localparam int          PhaseItems  = 315;
    localparam logic [2:0]  AddrPendingLimit = 3'd0;
    localparam logic [2:0]  AddrUnmapped     = 3'd4;
    localparam logic [15:0] CodeBracket = 16'h005D;
    localparam logic [15:0] CodeNine    = 16'h0039;
    localparam logic [15:0] CodeSemi    = 16'h003B;
    localparam logic [15:0] DirPrefix [6] = '{16'h001B, 16'h005D, 16'h0039,
                                              16'h003B, 16'h0039, 16'h003B};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;      // [15:0] code_unit
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [15:0] value_unit
    logic [1:0]  m_axis_tuser;           // [1:0] kind
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state, kept in step with every accepted request.
    logic [2:0]  dir_matched = '0;
    logic        dir_esc_held = 1'b0;
    logic [15:0] dir_count = '0;
    logic [15:0] dir_limit = LimitReset;

    logic [15:0] pending_codes[$];
    t_result     expected_dir_results[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned send_gap_left = 0;
    bit          send_idle_on = 1'b0;
    bit          recv_idle_on = 1'b0;

    osc_directory_sequence_extractor_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #(ClkPeriod / 2) i_clk = ~i_clk;
    end

    function automatic void expect_result(input logic [15:0] v, input logic [1:0] k);
        t_result r;
        r.value = v;
        r.kind  = k;
        r.last  = 1'b0;
        expected_dir_results.push_back(r);
    endfunction

    // Prefix matcher; a mismatching ESC starts a fresh match.
    function automatic void match_prefix_code(input logic [15:0] c);
        logic [2:0] m;
        m = (dir_matched >= InValue) ? 3'd0 : dir_matched;
        if (c == DirPrefix[m]) begin
            m = m + 3'd1;
        end else begin
            m = (c == ChEsc) ? 3'd1 : 3'd0;
        end
        dir_matched  = m;
        dir_esc_held = 1'b0;
        dir_count    = {13'd0, m};
    endfunction

    // Counts one value unit; returns 0 when it would go past the limit.
    function automatic bit take_value_unit();
        logic [16:0] next;
        next = {1'b0, dir_count} + 17'd1;
        if (next > {1'b0, dir_limit}) begin
            return 1'b0;
        end
        dir_count = next[15:0];
        return 1'b1;
    endfunction

    function automatic void close_value();
        dir_matched  = '0;
        dir_esc_held = 1'b0;
        dir_count    = '0;
    endfunction

    function automatic void abandon_value(input logic [15:0] c);
        expect_result('0, KindAbandon);
        close_value();
        match_prefix_code(c);
    endfunction

    function automatic void predict_dir_results(input logic [15:0] c);
        int  n_before;
        bit  done;
        n_before = expected_dir_results.size();
        done = 1'b0;
        if (dir_matched != InValue) begin
            match_prefix_code(c);
            return;
        end
        if (dir_esc_held) begin
            dir_esc_held = 1'b0;
            if (c == ChBslash) begin
                expect_result('0, KindEnd);
                close_value();
                done = 1'b1;
            end else if (!take_value_unit()) begin
                abandon_value(c);
                done = 1'b1;
            end else begin
                expect_result(ChEsc, KindValue);
            end
        end
        if (!done) begin
            if (c == ChBel) begin
                expect_result('0, KindEnd);
                close_value();
            end else if (c == ChEsc) begin
                dir_esc_held = 1'b1;
            end else if (!take_value_unit()) begin
                abandon_value(c);
            end else begin
                expect_result(c, KindValue);
            end
        end
        if (expected_dir_results.size() > n_before) begin
            expected_dir_results[expected_dir_results.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic int unsigned pick_gap_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    // Sender: presents the queued code units, one request at a time.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap_left = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_dir_results(s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap_left > 0) begin
                    send_gap_left = send_gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_codes.size() > 0) begin
                    s_axis_tdata  <= pending_codes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (send_idle_on && $urandom_range(0, 99) < 25) begin
                        send_gap_left = pick_gap_len();
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result and throttles tready.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_dir_results.size() == 0) begin
                    $display("%0t: unexpected result: value %h kind %0d last %0d",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    error_count++;
                end else begin
                    want = expected_dir_results.pop_front();
                    if (m_axis_tdata !== want.value || m_axis_tuser !== want.kind ||
                        m_axis_tlast !== want.last) begin
                        $display("%0t: mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                                 $time, want.value, want.kind, want.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served = holds_served + 1;
                hold_left = LongHold - 1;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 99) < 20) begin
                stall_left = pick_gap_len() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_dir_results.size());
            $display("osc_directory_sequence_extractor_unit_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [15:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == AddrPendingLimit) begin
            dir_limit = v;
        end
    endtask

    // Checked at the falling edge so that all updates of the rising edge are seen.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_codes.size() != 0 || s_axis_tvalid ||
               expected_dir_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SettleWait) @(posedge i_clk);
    endtask

    task automatic queue_prefix(input int n);
        for (int i = 0; i < n; i++) begin
            pending_codes.push_back(DirPrefix[i]);
        end
    endtask

    function automatic logic [15:0] pick_special();
        case ($urandom_range(0, 7))
            0:       return ChEsc;
            1:       return ChBel;
            2:       return ChBslash;
            3:       return CodeBracket;
            4:       return CodeNine;
            5:       return CodeSemi;
            6:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [15:0] pick_value_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 16'($urandom_range(16'h20, 16'h7E));
        end else if (r < 78) begin
            return 16'($urandom_range(0, 16'hFFFF));
        end else if (r < 90) begin
            return ChEsc;
        end
        case ($urandom_range(0, 2))
            0:       return CodeBracket;
            1:       return CodeNine;
            default: return CodeSemi;
        endcase
    endfunction

    // Mostly well-formed sequences with random values, plus noise and broken prefixes.
    task automatic queue_traffic(input int n_items);
        int          counted;
        int unsigned r;
        int unsigned len;
        counted = 0;
        while (counted < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_prefix(6);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 45)
                                                   : $urandom_range(0, 10);
                for (int i = 0; i < len; i++) begin
                    pending_codes.push_back(pick_value_code());
                end
                counted += 6 + len;
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    pending_codes.push_back(ChBel);
                    counted += 1;
                end else if (r < 85) begin
                    pending_codes.push_back(ChEsc);
                    pending_codes.push_back(ChBslash);
                    counted += 2;
                end
            end else if (r < 85) begin
                len = $urandom_range(1, 8);
                repeat (len) begin
                    pending_codes.push_back($urandom_range(0, 1) ? pick_special()
                                                                 : 16'($urandom));
                end
                counted += len;
            end else begin
                len = $urandom_range(1, 5);
                queue_prefix(len);
                pending_codes.push_back($urandom_range(0, 1) ? pick_special()
                                                             : 16'($urandom));
                counted += len + 1;
            end
        end
    endtask

    task automatic run_phase(input logic [15:0] limit, input bit idle_gaps,
                             input bit long_hold, input bit pause_midway);
        write_reg(AddrPendingLimit, limit);
        @(negedge i_clk);
        send_idle_on = idle_gaps;
        recv_idle_on = idle_gaps;
        if (long_hold) begin
            hold_requests++;
        end
        if (pause_midway) begin
            queue_traffic(PhaseItems / 2);
            wait_idle();
            @(negedge i_clk);
            queue_traffic(PhaseItems - PhaseItems / 2);
        end else begin
            queue_traffic(PhaseItems);
        end
        wait_idle();
    endtask

    initial begin
        logic [15:0] directed[$];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;

        // Restart inside the prefix, extreme units, held ESC then plain unit,
        // held ESC then ESC, and an ESC backslash end.
        directed = '{ChEsc, CodeBracket, ChEsc, CodeBracket, CodeNine, CodeSemi,
                     CodeNine, CodeSemi, 16'h0061, 16'hFFFF, ChEsc, 16'h0041,
                     ChEsc, ChEsc, ChBslash};
        foreach (directed[i]) pending_codes.push_back(directed[i]);
        wait_idle();

        // A limit below the prefix length: an empty value still completes, and
        // the overflowing ESC is fed back into the matcher.
        write_reg(AddrPendingLimit, 16'd5);
        @(negedge i_clk);
        queue_prefix(6);
        pending_codes.push_back(ChBel);
        queue_prefix(6);
        directed = '{ChEsc, ChEsc, CodeBracket, CodeNine, CodeSemi, CodeNine,
                     CodeSemi, ChBel};
        foreach (directed[i]) pending_codes.push_back(directed[i]);
        wait_idle();

        run_phase(16'd7, 1'b1, 1'b0, 1'b0);
        run_phase(16'd65535, 1'b0, 1'b1, 1'b0);
        run_phase(16'($urandom_range(8, 24)), 1'b1, 1'b0, 1'b1);
        write_reg(AddrUnmapped, 16'd9);
        run_phase(16'd5, 1'b1, 1'b0, 1'b0);
        run_phase(LimitReset, 1'b1, 1'b0, 1'b0);
        run_phase(16'($urandom_range(7, 40)), 1'b0, 1'b1, 1'b0);

        if (error_count == 0) begin
            $display("osc_directory_sequence_extractor_unit_tb: PASS");
        end else begin
            $display("osc_directory_sequence_extractor_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/osde_pkg.sv
rtl/osde_step.sv
rtl/osde_result_buf.sv
rtl/osc_directory_sequence_extractor_unit.sv
sim/osc_directory_sequence_extractor_unit_tb.sv
